### rtl/mtwg_pkg.sv
// mtwg_pkg: constants, state encoding and word functions for the mt19937 word generator
// no dependencies; used by mt19937_word_generator and mtwg_port_checker
`default_nettype none

package mtwg_pkg;

    localparam int STATE_WORDS_DEF   = 624;
    localparam int MIDDLE_OFFSET_DEF = 397;

    localparam logic [31:0] SEED_MULT    = 32'd6069;
    localparam logic [31:0] DEFAULT_SEED = 32'd4357;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_SEED = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_FILL     = 6'b000010,
        ST_TW_PRIME = 6'b000100,
        ST_TW_RUN   = 6'b001000,
        ST_TW_DRAIN = 6'b010000,
        ST_OUT      = 6'b100000
    } mtwg_state_t;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                               input logic [31:0] nxt,
                                               input logic [31:0] far_word);
        logic [31:0] y;
        logic [31:0] v;
        y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
        v = far_word ^ (y >> 1);
        if (y[0]) begin
            v = v ^ TWIST_MATRIX;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/mtwg_store.sv
// mtwg_store: state word memory, one write port and two registered read ports
// uses no package items; instantiated by mt19937_word_generator
`default_nettype none

module mtwg_store #(
    parameter int DEPTH = 624,
    parameter int AW    = 10
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [31:0]   wr_data,
    input  wire logic [AW-1:0] rd_a_addr,
    input  wire logic [AW-1:0] rd_b_addr,
    output logic      [31:0]   rd_a_data,
    output logic      [31:0]   rd_b_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

`default_nettype wire

### rtl/mt19937_word_generator.sv
// mt19937_word_generator: top level, command sequencer around the state word memory
// depends on mtwg_pkg and mtwg_store
`default_nettype none

//  channel | ports                                 | moves
//  --------+---------------------------------------+--------------------------------
//  input   | s_valid s_ready s_command s_seed_value | draw or reseed command
//  output  | m_valid m_ready m_random_word         | tempered word, one per draw
//
//  a draw with a word pending in the store does a memory read, then tempers the word into
//  the output register; a draw that finds the store used up first runs the twist,
//  one read-modify-write of the memory per cycle.
//  a reseed is accepted and then fills the memory, one memory write per cycle;
//  the first draw after reset does a 4357 seed fill before its twist.
//  reset clears the sequencer and marks the generator unseeded; the memory is not cleared.
//  a new command is taken while the output register still holds an untaken word;
//  a draw then waits for that word to leave.

module mt19937_word_generator #(
    parameter int STATE_WORDS   = mtwg_pkg::STATE_WORDS_DEF,
    parameter int MIDDLE_OFFSET = mtwg_pkg::MIDDLE_OFFSET_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic [31:0] s_seed_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_random_word
);

    import mtwg_pkg::*;

    localparam int AW = $clog2(STATE_WORDS);
    localparam int IW = $clog2(STATE_WORDS + 2);

    localparam logic [IW-1:0] IDX_TWIST    = IW'(STATE_WORDS);
    localparam logic [IW-1:0] IDX_UNSEEDED = IW'(STATE_WORDS + 1);
    localparam logic [AW-1:0] LAST_ADDR    = AW'(STATE_WORDS - 1);
    localparam logic [AW:0]   DEPTH_X      = (AW + 1)'(STATE_WORDS);
    localparam logic [AW:0]   OFFSET_X     = (AW + 1)'(MIDDLE_OFFSET);

    mtwg_state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [AW-1:0] k_reg, k_next;
    logic [31:0]   w_reg, w_next;
    logic          draw_pend_reg, draw_pend_next;
    logic          p_valid_reg, p_valid_next;
    logic [AW-1:0] p_idx_reg, p_idx_next;
    logic [31:0]   cur_reg, cur_next;
    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_word_reg, m_word_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [AW-1:0] rd_a_addr;
    logic [AW-1:0] rd_b_addr;
    logic [31:0]   rd_a_data;
    logic [31:0]   rd_b_data;

    logic [AW:0]   far_sum;
    logic [AW:0]   far_wrap;
    logic [AW-1:0] far_addr;
    logic [AW-1:0] k_inc;
    logic [31:0]   w_prod;
    logic [31:0]   tw_word;

    assign far_sum  = {1'b0, k_reg} + OFFSET_X;
    assign far_wrap = (far_sum >= DEPTH_X) ? (far_sum - DEPTH_X) : far_sum;
    assign far_addr = far_wrap[AW-1:0];
    assign k_inc    = k_reg + AW'(1);
    assign w_prod   = w_reg * SEED_MULT;
    assign tw_word  = twist_word(cur_reg, rd_a_data, rd_b_data);

    mtwg_store #(
        .DEPTH (STATE_WORDS),
        .AW    (AW)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        w_next         = w_reg;
        draw_pend_next = draw_pend_reg;
        p_valid_next   = 1'b0;
        p_idx_next     = p_idx_reg;
        cur_next       = cur_reg;
        m_valid_next   = m_valid_reg;
        m_word_next    = m_word_reg;
        s_ready        = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = k_reg;
        wr_data        = w_reg;
        rd_a_addr      = idx_reg[AW-1:0];
        rd_b_addr      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                // read at idx is issued speculatively for a plain draw
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_command == CMD_SEED) begin
                        w_next         = s_seed_value;
                        k_next         = '0;
                        draw_pend_next = 1'b0;
                        state_next     = ST_FILL;
                    end else if (idx_reg >= IDX_UNSEEDED) begin
                        w_next         = DEFAULT_SEED;
                        k_next         = '0;
                        draw_pend_next = 1'b1;
                        state_next     = ST_FILL;
                    end else if (idx_reg == IDX_TWIST) begin
                        state_next = ST_TW_PRIME;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_FILL: begin
                wr_en   = 1'b1;
                wr_addr = k_reg;
                wr_data = w_reg;
                w_next  = w_prod;
                k_next  = k_inc;
                if (k_reg == LAST_ADDR) begin
                    k_next     = '0;
                    idx_next   = IDX_TWIST;
                    state_next = draw_pend_reg ? ST_TW_PRIME : ST_IDLE;
                end
            end
            ST_TW_PRIME: begin
                // fetch word 0 so the first step has its current word
                rd_a_addr  = '0;
                k_next     = '0;
                state_next = ST_TW_RUN;
            end
            ST_TW_RUN: begin
                // issue reads for step k while writing back step k-1
                rd_a_addr    = (k_reg == LAST_ADDR) ? '0 : k_inc;
                rd_b_addr    = far_addr;
                p_valid_next = 1'b1;
                p_idx_next   = k_reg;
                cur_next     = rd_a_data;
                wr_en        = p_valid_reg;
                wr_addr      = p_idx_reg;
                wr_data      = tw_word;
                k_next       = k_inc;
                if (k_reg == LAST_ADDR) begin
                    k_next     = '0;
                    idx_next   = '0;
                    state_next = ST_TW_DRAIN;
                end
            end
            ST_TW_DRAIN: begin
                // last write back; word 0 was rewritten long ago, safe to read now
                wr_en      = p_valid_reg;
                wr_addr    = p_idx_reg;
                wr_data    = tw_word;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_word_next  = temper(rd_a_data);
                    idx_next     = idx_reg + IW'(1);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= IDX_UNSEEDED;
            k_reg         <= '0;
            draw_pend_reg <= 1'b0;
            p_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            draw_pend_reg <= draw_pend_next;
            p_valid_reg   <= p_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg      <= w_next;
        p_idx_reg  <= p_idx_next;
        cur_reg    <= cur_next;
        m_word_reg <= m_word_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_random_word = m_word_reg;

endmodule

`default_nettype wire

### rtl/mtwg_port_checker.sv
// mtwg_port_checker: port-level assertions for mt19937_word_generator, with its bind
// depends on mtwg_pkg for the command codes
`default_nettype none

module mtwg_port_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_command,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_random_word
);

    import mtwg_pkg::*;

    logic seed_acc;
    assign seed_acc = s_valid && s_ready && (s_command == CMD_SEED);

    // a stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_random_word))
        else $error("output word changed while stalled");

    // after reset the block takes a command and shows no word
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("bad state after reset");

    // after every accepted command the block is busy in the next cycle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command taken back to back");

    // a reseed never yields a word in the next cycle
    a_seed_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        seed_acc && !m_valid |=> !m_valid)
        else $error("word after reseed");

    // a new word only comes out of the busy draw phase
    a_word_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("word appeared without a draw");

endmodule

bind mt19937_word_generator mtwg_port_checker u_mtwg_port_checker (.*);

`default_nettype wire
